// ----- sv/fdc_pkg.sv -----
// Package for the frame deframer with CRC-16/Modbus check.
// Holds frame layout constants, status codes, register indexes and the bytewise CRC update.
// No dependencies.
`default_nettype none

package fdc_pkg;

	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned CNT_W     = 17;
	localparam int unsigned CRC_W     = 16;
	localparam int unsigned STATUS_W  = 3;
	localparam int unsigned OUT_DATA_W = 152;   // 147 field bits padded to whole bytes

	localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
	localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;
	localparam logic [CNT_W-1:0] HDR_LEN  = 17'd16;
	localparam logic [CNT_W:0]   MIN_FRAME = 18'd19;
	localparam logic [CNT_W-1:0] COUNT_MAX = 17'h1FFFF;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 3'd0,
		ST_SHORT     = 3'd1,
		ST_LEN_BAD   = 3'd2,
		ST_FRAME_BAD = 3'd3,
		ST_CRC_BAD   = 3'd4
	} status_t;

	typedef enum logic {
		KIND_BODY    = 1'b0,
		KIND_SUMMARY = 1'b1
	} kind_t;

	localparam logic REG_HEADER = 1'b0;
	localparam logic REG_FOOTER = 1'b1;

	// one byte of reflected CRC-16, eight shift steps
	function automatic logic [CRC_W-1:0] crc16_byte(input logic [CRC_W-1:0] crc,
		input logic [BYTE_W-1:0] b);
		logic [CRC_W-1:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// ----- sv/frame_deframer_crc16.sv -----
// Byte-serial frame parser: header capture, body pass-through, CRC-16/Modbus check.
// Depends on fdc_pkg.
`default_nettype none

// Usage
//  s_axis: one frame byte per transaction (tdata = rx_byte), tlast marks the final byte
//    of the received buffer and closes the frame.
//  m_axis: at most one result per input byte. tuser = kind: 0 carries a body byte,
//    1 carries the end-of-frame summary (status, captured header fields, received CRC).
//    Header and CRC bytes produce no result; the closing byte gives only the summary.
//  cfg: cfg_we writes cfg_wdata to register cfg_addr (0 header_byte, 1 footer_byte);
//    write only while no frame byte is in flight.
//  Timing: a byte is held in the input register; the CRC, counter and checks run in one
//    pass into the result register, which drives m_axis. One byte per cycle sustained
//    while m_tready stays high; the bytewise CRC update in the single processing stage
//    bounds the clock.
//  Stall: with m_tready low a held result keeps the stage busy; one more byte still
//    enters the input register, then s_tready drops until the result is taken.
//  Reset: arst_n clears valid flags, config and frame state to 0, CRC to 0xFFFF. After each
//    summary the frame state returns to that reset value; the config registers are kept.
//  Long frames: the byte counter saturates at 2^17-1 and the frame fails the length check.
module frame_deframer_crc16 (
	input  wire logic         clk,
	input  wire logic         arst_n,
	// slave stream
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [7:0]   s_tdata,    // [7:0] rx_byte
	input  wire logic         s_tlast,    // end_of_buffer
	// master stream
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// [7:0] body_byte, [10:8] status, [18:11] device_type, [26:19] action_code,
	// [34:27] reserved_byte, [66:35] transaction_id, [82:67] source device,
	// [98:83] target device, [114:99] message_type, [130:115] payload_length,
	// [146:131] frame_crc, [151:147] zero
	output logic [fdc_pkg::OUT_DATA_W-1:0] m_tdata,
	output logic [0:0]        m_tuser,    // [0] kind
	// configuration
	input  wire logic         cfg_we,
	input  wire logic         cfg_addr,
	input  wire logic [7:0]   cfg_wdata
);

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// configuration registers
	logic [7:0] header_q, footer_q;

	// frame state
	logic [fdc_pkg::CNT_W-1:0] cnt_q;
	logic [15:0] run_crc_q, body_crc_q;
	logic [7:0]  first_q, type_q, action_q, rsvd_q;
	logic [31:0] tid_q;
	logic [15:0] src_q, tgt_q, subtype_q, len_q, rx_crc_q;

	// next-state values for the byte in the input register
	logic [7:0]  first_nxt, type_nxt, action_nxt, rsvd_nxt;
	logic [31:0] tid_nxt;
	logic [15:0] src_nxt, tgt_nxt, subtype_nxt, len_nxt, rx_crc_nxt;
	logic [15:0] run_crc_nxt, body_crc_nxt;
	logic [fdc_pkg::CNT_W-1:0] body_end;
	logic [fdc_pkg::CNT_W:0]   total;
	logic        is_body;
	fdc_pkg::status_t status;

	// result register
	logic        out_valid_q;
	logic        kind_q;
	logic [7:0]  body_q;
	logic [2:0]  status_q;
	logic [7:0]  o_type_q, o_action_q, o_rsvd_q;
	logic [31:0] o_tid_q;
	logic [15:0] o_src_q, o_tgt_q, o_subtype_q, o_len_q, o_crc_q;

	logic advance;

	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	// header capture for this byte position
	always_comb begin
		first_nxt   = first_q;
		type_nxt    = type_q;
		action_nxt  = action_q;
		rsvd_nxt    = rsvd_q;
		tid_nxt     = tid_q;
		src_nxt     = src_q;
		tgt_nxt     = tgt_q;
		subtype_nxt = subtype_q;
		len_nxt     = len_q;
		unique case (cnt_q)
			17'd0:  first_nxt          = byte_s1;
			17'd1:  type_nxt           = byte_s1;
			17'd2:  action_nxt         = byte_s1;
			17'd3:  rsvd_nxt           = byte_s1;
			17'd4:  tid_nxt[7:0]       = byte_s1;
			17'd5:  tid_nxt[15:8]      = byte_s1;
			17'd6:  tid_nxt[23:16]     = byte_s1;
			17'd7:  tid_nxt[31:24]     = byte_s1;
			17'd8:  src_nxt[7:0]       = byte_s1;
			17'd9:  src_nxt[15:8]      = byte_s1;
			17'd10: tgt_nxt[7:0]       = byte_s1;
			17'd11: tgt_nxt[15:8]      = byte_s1;
			17'd12: subtype_nxt[7:0]   = byte_s1;
			17'd13: subtype_nxt[15:8]  = byte_s1;
			17'd14: len_nxt[7:0]       = byte_s1;
			17'd15: len_nxt[15:8]      = byte_s1;
			default: ;
		endcase
	end

	// body end uses the length as just updated, so with a zero-length body the CRC snapshot is taken at byte 15
	assign body_end    = fdc_pkg::HDR_LEN + {1'b0, len_nxt};
	assign run_crc_nxt = fdc_pkg::crc16_byte(run_crc_q, byte_s1);
	assign total       = {1'b0, cnt_q} + 18'd1;

	always_comb begin
		rx_crc_nxt = rx_crc_q;
		if (cnt_q == body_end) begin
			rx_crc_nxt[7:0] = byte_s1;
		end else if ({1'b0, cnt_q} == {1'b0, body_end} + 18'd1) begin
			rx_crc_nxt[15:8] = byte_s1;
		end
	end

	assign body_crc_nxt = (total == {1'b0, body_end}) ? run_crc_nxt : body_crc_q;
	assign is_body      = (cnt_q >= fdc_pkg::HDR_LEN) && (cnt_q < body_end);

	// checks in priority order
	always_comb begin
		priority if (total < fdc_pkg::MIN_FRAME) begin
			status = fdc_pkg::ST_SHORT;
		end else if (total != {2'b00, len_nxt} + fdc_pkg::MIN_FRAME) begin
			status = fdc_pkg::ST_LEN_BAD;
		end else if (first_nxt != header_q || byte_s1 != footer_q) begin
			status = fdc_pkg::ST_FRAME_BAD;
		end else if (rx_crc_nxt != body_crc_nxt) begin
			status = fdc_pkg::ST_CRC_BAD;
		end else begin
			status = fdc_pkg::ST_OK;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q <= '0;
			footer_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				fdc_pkg::REG_HEADER: header_q <= cfg_wdata;
				fdc_pkg::REG_FOOTER: footer_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// frame state: cleared on the closing byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			run_crc_q  <= fdc_pkg::CRC_INIT;
			body_crc_q <= '0;
			first_q    <= '0;
			type_q     <= '0;
			action_q   <= '0;
			rsvd_q     <= '0;
			tid_q      <= '0;
			src_q      <= '0;
			tgt_q      <= '0;
			subtype_q  <= '0;
			len_q      <= '0;
			rx_crc_q   <= '0;
		end else if (advance) begin
			if (last_s1) begin
				cnt_q      <= '0;
				run_crc_q  <= fdc_pkg::CRC_INIT;
				body_crc_q <= '0;
				first_q    <= '0;
				type_q     <= '0;
				action_q   <= '0;
				rsvd_q     <= '0;
				tid_q      <= '0;
				src_q      <= '0;
				tgt_q      <= '0;
				subtype_q  <= '0;
				len_q      <= '0;
				rx_crc_q   <= '0;
			end else begin
				if (cnt_q != fdc_pkg::COUNT_MAX) begin
					cnt_q <= cnt_q + 17'd1;
				end
				run_crc_q  <= run_crc_nxt;
				body_crc_q <= body_crc_nxt;
				first_q    <= first_nxt;
				type_q     <= type_nxt;
				action_q   <= action_nxt;
				rsvd_q     <= rsvd_nxt;
				tid_q      <= tid_nxt;
				src_q      <= src_nxt;
				tgt_q      <= tgt_nxt;
				subtype_q  <= subtype_nxt;
				len_q      <= len_nxt;
				rx_crc_q   <= rx_crc_nxt;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= last_s1 || is_body;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			if (last_s1) begin
				kind_q      <= fdc_pkg::KIND_SUMMARY;
				body_q      <= '0;
				status_q    <= status;
				o_type_q    <= type_nxt;
				o_action_q  <= action_nxt;
				o_rsvd_q    <= rsvd_nxt;
				o_tid_q     <= tid_nxt;
				o_src_q     <= src_nxt;
				o_tgt_q     <= tgt_nxt;
				o_subtype_q <= subtype_nxt;
				o_len_q     <= len_nxt;
				o_crc_q     <= rx_crc_nxt;
			end else begin
				kind_q      <= fdc_pkg::KIND_BODY;
				body_q      <= byte_s1;
				status_q    <= fdc_pkg::ST_OK;
				o_type_q    <= '0;
				o_action_q  <= '0;
				o_rsvd_q    <= '0;
				o_tid_q     <= '0;
				o_src_q     <= '0;
				o_tgt_q     <= '0;
				o_subtype_q <= '0;
				o_len_q     <= '0;
				o_crc_q     <= '0;
			end
		end
	end

	assign m_tvalid   = out_valid_q;
	assign m_tuser[0] = kind_q;
	assign m_tdata    = {5'b00000, o_crc_q, o_len_q, o_subtype_q, o_tgt_q, o_src_q,
		o_tid_q, o_rsvd_q, o_action_q, o_type_q, status_q, body_q};

endmodule

`default_nettype wire
